// ----- sv/coalescing_overwrite_line_queue_core_assert.svh -----
// assertion macros for the line queue core
`ifndef COALESCING_OVERWRITE_LINE_QUEUE_CORE_ASSERT_SVH
`define COALESCING_OVERWRITE_LINE_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
`define COLQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define COLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define COLQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define COLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/colq_pkg.sv -----
package colq_pkg;

	localparam int COLQ_DEPTH = 16;
	localparam int COLQ_PAYLOAD_BITS = 64;

	localparam int ID_W = 32;
	localparam int KIND_W = 8;
	localparam int LEN_W = 8;
	localparam int PAY_PORT_W = 64;
	localparam int COUNT_OUT_W = 4;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	typedef struct packed {
		logic load;
		logic rd_scan;
		logic scan_next;
		logic do_push;
		logic do_hit;
		logic rd_pop;
		logic do_pop;
		logic do_empty;
		logic do_nop;
	} colq_cmd_t;

	typedef struct packed {
		logic empty;
		logic scan_end;
		logic hit;
	} colq_sts_t;

endpackage

// ----- sv/coalescing_overwrite_line_queue_core.sv -----
// Ring queue of message entries with overwrite-oldest push and key coalescing.
// Command channel: start with mode, msg_id, msg_kind, line_length, payload;
// a beat is taken at a clock edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with was_empty, out_id,
// out_kind, out_length, out_payload, replaced, dropped_oldest, queue_count.
// Push is finished in the PUSH state; pop in POP and POPOUT, or in POP alone
// on an empty queue; a no-op in the idle state that accepts it. Replace walks
// the entries from oldest to newest, one read and one compare of the entry
// memory per entry in the SCAN and CMP states, until one matches.
// busy drops in the done cycle, so a new beat can be taken there.
// One item is in work at a time; the single read port of the entry memory
// and the key compare set the replace time.
// Reset empties the queue (the read, write and scan pointers and the count
// to zero); entry contents are not cleared and are only read once written.
// The receiver cannot stall: each result is shown once and must be taken.
module coalescing_overwrite_line_queue_core #(
	parameter int QUEUE_DEPTH = colq_pkg::COLQ_DEPTH,
	parameter int PAYLOAD_BITS = colq_pkg::COLQ_PAYLOAD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [colq_pkg::MODE_W-1:0]       mode,
	input  logic [colq_pkg::ID_W-1:0]         msg_id,
	input  logic [colq_pkg::KIND_W-1:0]       msg_kind,
	input  logic [colq_pkg::LEN_W-1:0]        line_length,
	input  logic [colq_pkg::PAY_PORT_W-1:0]   payload,
	output logic                              done,
	output logic                              was_empty,
	output logic [colq_pkg::ID_W-1:0]         out_id,
	output logic [colq_pkg::KIND_W-1:0]       out_kind,
	output logic [colq_pkg::LEN_W-1:0]        out_length,
	output logic [colq_pkg::PAY_PORT_W-1:0]   out_payload,
	output logic                              replaced,
	output logic                              dropped_oldest,
	output logic [colq_pkg::COUNT_OUT_W-1:0]  queue_count
);
	import colq_pkg::*;

	colq_cmd_t cmd;
	colq_sts_t sts;

	colq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	colq_datapath #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.msg_id         (msg_id),
		.msg_kind       (msg_kind),
		.line_length    (line_length),
		.payload        (payload),
		.done           (done),
		.was_empty      (was_empty),
		.out_id         (out_id),
		.out_kind       (out_kind),
		.out_length     (out_length),
		.out_payload    (out_payload),
		.replaced       (replaced),
		.dropped_oldest (dropped_oldest),
		.queue_count    (queue_count)
	);

endmodule

// ----- sv/colq_ctrl.sv -----
module colq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [colq_pkg::MODE_W-1:0]   mode,
	output logic                          busy,
	output colq_pkg::colq_cmd_t           cmd,
	input  colq_pkg::colq_sts_t           sts
);
	import colq_pkg::*;

	`include "coalescing_overwrite_line_queue_core_assert.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUSH = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_CMP = 3'd3;
	localparam logic [2:0] S_POP = 3'd4;
	localparam logic [2:0] S_POPOUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (mode)
						MODE_PUSH: state_d = S_PUSH;
						MODE_REPLACE: state_d = S_SCAN;
						MODE_POP: state_d = S_POP;
						MODE_NOP: cmd.do_nop = 1'b1;
					endcase
				end
			end
			S_PUSH: begin
				cmd.do_push = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					cmd.do_push = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_scan = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.hit) begin
					cmd.do_hit = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_POP: begin
				if (sts.empty) begin
					cmd.do_empty = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_pop = 1'b1;
					state_d = S_POPOUT;
				end
			end
			S_POPOUT: begin
				cmd.do_pop = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`COLQ_ASSERT_NOW(a_one_finish, clk, arst_n, 1'b1,
		$onehot0({cmd.do_push, cmd.do_hit, cmd.do_pop, cmd.do_empty, cmd.do_nop}))
	`COLQ_ASSERT_NOW(a_cmp_after_scan, clk, arst_n, state_q == S_CMP, $past(state_q) == S_SCAN)
	`COLQ_ASSERT_NEXT(a_pop_entry, clk, arst_n, start && !busy && mode == MODE_POP,
		state_q == S_POP)

endmodule

// ----- sv/colq_datapath.sv -----
module colq_datapath #(
	parameter int QUEUE_DEPTH = colq_pkg::COLQ_DEPTH,
	parameter int PAYLOAD_BITS = colq_pkg::COLQ_PAYLOAD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  colq_pkg::colq_cmd_t               cmd,
	output colq_pkg::colq_sts_t               sts,
	input  logic [colq_pkg::ID_W-1:0]         msg_id,
	input  logic [colq_pkg::KIND_W-1:0]       msg_kind,
	input  logic [colq_pkg::LEN_W-1:0]        line_length,
	input  logic [colq_pkg::PAY_PORT_W-1:0]   payload,
	output logic                              done,
	output logic                              was_empty,
	output logic [colq_pkg::ID_W-1:0]         out_id,
	output logic [colq_pkg::KIND_W-1:0]       out_kind,
	output logic [colq_pkg::LEN_W-1:0]        out_length,
	output logic [colq_pkg::PAY_PORT_W-1:0]   out_payload,
	output logic                              replaced,
	output logic                              dropped_oldest,
	output logic [colq_pkg::COUNT_OUT_W-1:0]  queue_count
);
	import colq_pkg::*;

	`include "coalescing_overwrite_line_queue_core_assert.svh"

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_EXT_W = (PTR_W > COUNT_OUT_W) ? PTR_W : COUNT_OUT_W;
	localparam int ENTRY_W = ID_W + KIND_W + LEN_W + PAYLOAD_BITS;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;
	logic [ENTRY_W-1:0] new_entry;

	logic [ID_W-1:0]         id_q;
	logic [KIND_W-1:0]       kind_q;
	logic [LEN_W-1:0]        len_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] scan_q;
	logic [PTR_W-1:0] cnt_q;
	logic [PTR_W-1:0] rp_inc;
	logic [PTR_W-1:0] wp_inc;
	logic [PTR_W-1:0] scan_inc;
	logic [CNT_EXT_W-1:0] cnt_ext;
	logic full;

	logic [ID_W-1:0]         rd_id;
	logic [KIND_W-1:0]       rd_kind;
	logic [LEN_W-1:0]        rd_len;
	logic [PAYLOAD_BITS-1:0] rd_pay;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	assign rp_inc = next_slot(rp_q);
	assign wp_inc = next_slot(wp_q);
	assign scan_inc = next_slot(scan_q);
	assign full = (cnt_q == LAST_SLOT);

	assign new_entry = {id_q, kind_q, len_q, pay_q};
	assign {rd_id, rd_kind, rd_len, rd_pay} = rdata_q;

	assign sts.empty = (cnt_q == '0);
	assign sts.scan_end = (scan_q == wp_q);
	assign sts.hit = (rd_id == id_q) && (rd_kind == kind_q);

	// beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= msg_id;
			kind_q <= msg_kind;
			len_q <= line_length;
			pay_q <= payload[PAYLOAD_BITS-1:0];
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (cmd.do_push) begin
			mem_q[wp_q] <= new_entry;
		end else if (cmd.do_hit) begin
			mem_q[scan_q] <= new_entry;
		end
		if (cmd.rd_pop) begin
			rdata_q <= mem_q[rp_q];
		end else if (cmd.rd_scan) begin
			rdata_q <= mem_q[scan_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			scan_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				scan_q <= rp_q;
			end else if (cmd.scan_next) begin
				scan_q <= scan_inc;
			end
			if (cmd.do_push) begin
				wp_q <= wp_inc;
				if (full) begin
					rp_q <= rp_inc;
				end else begin
					cnt_q <= cnt_q + PTR_W'(1);
				end
			end else if (cmd.do_pop) begin
				rp_q <= rp_inc;
				cnt_q <= cnt_q - PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.do_push | cmd.do_hit | cmd.do_pop | cmd.do_empty | cmd.do_nop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_push | cmd.do_hit | cmd.do_pop | cmd.do_empty | cmd.do_nop) begin
			was_empty <= cmd.do_empty;
			replaced <= cmd.do_hit;
			dropped_oldest <= cmd.do_push & full;
			out_id <= cmd.do_pop ? rd_id : '0;
			out_kind <= cmd.do_pop ? rd_kind : '0;
			out_length <= cmd.do_pop ? rd_len : '0;
			out_payload <= cmd.do_pop ? PAY_PORT_W'(rd_pay) : '0;
		end
	end

	assign cnt_ext = CNT_EXT_W'(cnt_q);
	assign queue_count = cnt_ext[COUNT_OUT_W-1:0];

	`COLQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, cnt_q <= LAST_SLOT)
	`COLQ_ASSERT_NOW(a_pop_not_empty, clk, arst_n, cmd.do_pop, cnt_q != '0)
	`COLQ_ASSERT_NEXT(a_push_fills, clk, arst_n, cmd.do_push, cnt_q != '0)
	`COLQ_ASSERT_NOW(a_flags_excl, clk, arst_n, done, !(replaced && dropped_oldest))

endmodule
